>>> rtl/fpfir_pkg.sv
// Shared constants, register codes and types of the fixed-point FIR filter.
// Used by fpfir_cell, fpfir_mac and fixed_point_fir_filter; depends on nothing.
`default_nettype none

package fpfir_pkg;

  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int TAP_W        = 7;
  localparam int FRAC_W       = 5;
  localparam int IDX_W        = 6;
  localparam int MAX_TAPS_DEF = 64;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [0:0] REG_TAP_COUNT = 1'b0;
  localparam logic [0:0] REG_FRAC_BITS = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic [TAP_W-1:0]  TAP_COUNT_RST = 7'd64;
  localparam logic [FRAC_W-1:0] FRAC_BITS_RST = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic take;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/fixed_point_fir_filter.sv
// Top level of the fixed-point FIR filter: APB registers, sequencer, cell chain, MAC.
// Depends on fpfir_pkg, fpfir_cell and fpfir_mac.
//
//   port group      | direction | handshake                 | payload
//   ----------------+-----------+---------------------------+------------------------------
//   input items     | in        | in_valid_i / in_stall_o   | mode_i, coef_index_i, value_i
//   result items    | out       | out_valid_o / out_stall_i | filtered_sample_o
//   registers       | in/out    | psel, penable, pready     | paddr, pwdata, prdata
//
// A coefficient transaction is written straight into its cell and the block stays idle.
// A sample transaction shifts the chain, then rotates it once around through the MAC:
// a new transaction is taken only once the sequencer has left run, drain and done for idle.
// The result goes to an output register, so a stalled result only holds the next sample.
// Reset clears both registers to their defaults and every cell of the chain to zero.
`default_nettype none

module fixed_point_fir_filter #(
  parameter int unsigned MAX_TAPS = fpfir_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic                                    mode_i,
  input  wire logic [fpfir_pkg::IDX_W-1:0]             coef_index_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0]     value_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [fpfir_pkg::DATA_W-1:0]          filtered_sample_o,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [fpfir_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [fpfir_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [fpfir_pkg::APB_DATA_W-1:0]             prdata,
  output logic                                         pready
);

  localparam int CNT_W  = $clog2(MAX_TAPS);
  localparam int CMP_W  = (CNT_W > fpfir_pkg::TAP_W) ? CNT_W : fpfir_pkg::TAP_W;
  localparam int WIDX_W = (CNT_W > fpfir_pkg::IDX_W) ? CNT_W : fpfir_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

  logic [fpfir_pkg::TAP_W-1:0]  tap_count_q;
  logic [fpfir_pkg::FRAC_W-1:0] frac_bits_q;
  logic                         cfg_we;

  fpfir_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic signed [fpfir_pkg::DATA_W-1:0] out_data_q;

  logic                    in_take;
  logic                    coef_wr;
  logic                    sample_take;
  logic                    out_load;
  logic                    use_tap;
  fpfir_pkg::cell_ctrl_t   cell_ctrl;
  fpfir_pkg::mac_ctrl_t    mac_ctrl;
  logic signed [fpfir_pkg::DATA_W-1:0] acc;

  logic signed [fpfir_pkg::DATA_W-1:0] dly  [MAX_TAPS];
  logic signed [fpfir_pkg::DATA_W-1:0] coef [MAX_TAPS];

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fpfir_pkg::TAP_COUNT_RST;
      frac_bits_q <= fpfir_pkg::FRAC_BITS_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        fpfir_pkg::REG_TAP_COUNT: tap_count_q <= pwdata[fpfir_pkg::TAP_W-1:0];
        fpfir_pkg::REG_FRAC_BITS: frac_bits_q <= pwdata[fpfir_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fpfir_pkg::REG_TAP_COUNT: prdata = fpfir_pkg::APB_DATA_W'(tap_count_q);
      fpfir_pkg::REG_FRAC_BITS: prdata = fpfir_pkg::APB_DATA_W'(frac_bits_q);
      default:                  prdata = '0;
    endcase
  end

  // Sequencer
  assign in_stall_o  = (state_q != fpfir_pkg::S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign coef_wr     = in_take && (mode_i == fpfir_pkg::MODE_COEF);
  assign sample_take = in_take && (mode_i == fpfir_pkg::MODE_SAMPLE);
  assign use_tap     = CMP_W'(cnt_q) < CMP_W'(tap_count_q);
  assign out_load    = (state_q == fpfir_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.take    = 1'b0;
    unique case (state_q)
      fpfir_pkg::S_IDLE: begin
        if (sample_take) begin
          cell_ctrl.shift = 1'b1;
          mac_ctrl.clear  = 1'b1;
          cnt_d           = '0;
          state_d         = fpfir_pkg::S_RUN;
        end
      end
      fpfir_pkg::S_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.take    = use_tap;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = fpfir_pkg::S_DRAIN;
        end
      end
      fpfir_pkg::S_DRAIN: begin
        state_d = fpfir_pkg::S_DONE;
      end
      fpfir_pkg::S_DONE: begin
        if (out_load) begin
          state_d = fpfir_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fpfir_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpfir_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= acc;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;

  // Cell chain: shift toward the tail on a sample, rotate toward the head while running
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_TAPS;
    logic signed [fpfir_pkg::DATA_W-1:0] dly_prev;
    logic                                 cell_we;

    if (i == 0) begin : g_head
      assign dly_prev = value_i;
    end else begin : g_body
      assign dly_prev = dly[i-1];
    end

    assign cell_we = coef_wr && (WIDX_W'(coef_index_i) == WIDX_W'(i));

    fpfir_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .coef_we_i    (cell_we),
      .coef_wdata_i (value_i),
      .dly_prev_i   (dly_prev),
      .dly_next_i   (dly[NXT]),
      .coef_next_i  (coef[NXT]),
      .dly_o        (dly[i]),
      .coef_o       (coef[i])
    );
  end

  fpfir_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .frac_bits_i (frac_bits_q),
    .coef_i      (coef[0]),
    .sample_i    (dly[0]),
    .acc_o       (acc)
  );

  a_sample_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_take |=> (state_q == fpfir_pkg::S_RUN && cnt_q == '0))
    else $error("sample transaction did not start a rotation");

  a_run_ends_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpfir_pkg::S_RUN && cnt_q == CNT_LAST) |=> (state_q == fpfir_pkg::S_DRAIN))
    else $error("rotation did not end after a full turn");

  a_drain_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpfir_pkg::S_DRAIN) |=> (state_q == fpfir_pkg::S_DONE))
    else $error("drain did not hand over to done");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == fpfir_pkg::S_DONE))
    else $error("result raised outside done");

endmodule

`default_nettype wire

>>> rtl/fpfir_cell.sv
// One cell of the circulating chain: one delay-line sample and one coefficient.
// Depends on fpfir_pkg.
`default_nettype none

module fpfir_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire fpfir_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic                               coef_we_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] coef_wdata_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] dly_prev_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] dly_next_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] coef_next_i,
  output logic signed [fpfir_pkg::DATA_W-1:0]      dly_o,
  output logic signed [fpfir_pkg::DATA_W-1:0]      coef_o
);

  logic signed [fpfir_pkg::DATA_W-1:0] dly_q, dly_d;
  logic signed [fpfir_pkg::DATA_W-1:0] coef_q, coef_d;

  always_comb begin
    dly_d  = dly_q;
    coef_d = coef_q;
    priority if (ctrl_i.shift) begin
      dly_d = dly_prev_i;
    end else if (ctrl_i.rotate) begin
      dly_d  = dly_next_i;
      coef_d = coef_next_i;
    end else if (coef_we_i) begin
      coef_d = coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q  <= '0;
      coef_q <= '0;
    end else begin
      dly_q  <= dly_d;
      coef_q <= coef_d;
    end
  end

  assign dly_o  = dly_q;
  assign coef_o = coef_q;

endmodule

`default_nettype wire

>>> rtl/fpfir_mac.sv
// Registered 32x32 multiplier followed by arithmetic scaling and a wrapping accumulator.
// Depends on fpfir_pkg.
`default_nettype none

module fpfir_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fpfir_pkg::mac_ctrl_t                ctrl_i,
  input  wire logic [fpfir_pkg::FRAC_W-1:0]        frac_bits_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] coef_i,
  input  wire logic signed [fpfir_pkg::DATA_W-1:0] sample_i,
  output logic signed [fpfir_pkg::DATA_W-1:0]      acc_o
);

  logic signed [fpfir_pkg::PROD_W-1:0] prod_q;
  logic                                take_q;
  logic signed [fpfir_pkg::PROD_W-1:0] scaled;
  logic signed [fpfir_pkg::DATA_W-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
  end

  assign scaled = prod_q >>> frac_bits_i;

  always_comb begin
    acc_d = acc_q;
    priority if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (take_q) begin
      acc_d = acc_q + scaled[fpfir_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      take_q <= ctrl_i.take;
      acc_q  <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> tb/fpfir_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the fixed-point FIR filter: follows register writes and transactions,
// predicts each filtered sample and compares it with the output. Depends on fpfir_pkg.
module fpfir_checker #(
  parameter int unsigned MAX_TAPS = fpfir_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic                                  mode_i,
  input  logic [fpfir_pkg::IDX_W-1:0]           coef_index_i,
  input  logic [fpfir_pkg::DATA_W-1:0]          value_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [fpfir_pkg::DATA_W-1:0]          filtered_sample_i,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [fpfir_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fpfir_pkg::APB_DATA_W-1:0]      pwdata,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o
);
  import fpfir_pkg::*;

  logic [TAP_W-1:0]  tap_count_q;
  logic [FRAC_W-1:0] frac_bits_q;
  logic [DATA_W-1:0] sample_history [MAX_TAPS];
  logic [DATA_W-1:0] coef_shadow [MAX_TAPS];
  logic [DATA_W-1:0] expected_samples [$];

  function automatic logic [DATA_W-1:0] scaled_product(
    input logic signed [DATA_W-1:0] coef,
    input logic signed [DATA_W-1:0] sample_word,
    input logic [FRAC_W-1:0]        frac
  );
    logic signed [PROD_W-1:0] product;
    product = coef * sample_word;
    product = product >>> frac;
    return product[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] filter_output();
    int unsigned       taps;
    logic [DATA_W-1:0] acc;
    taps = (tap_count_q > MAX_TAPS) ? MAX_TAPS : tap_count_q;
    acc  = '0;
    for (int unsigned k = 0; k < taps; k++) begin
      acc += scaled_product(coef_shadow[k], sample_history[k], frac_bits_q);
    end
    return acc;
  endfunction

  always @(posedge clk_i) begin : monitor
    logic [DATA_W-1:0] expected;
    if (!rst_ni) begin
      tap_count_q = TAP_COUNT_RST;
      frac_bits_q = FRAC_BITS_RST;
      for (int k = 0; k < MAX_TAPS; k++) begin
        sample_history[k] = '0;
        coef_shadow[k]    = '0;
      end
      expected_samples.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT) begin
          tap_count_q = pwdata[TAP_W-1:0];
        end else if (paddr[APB_ADDR_W-1:2] == REG_FRAC_BITS) begin
          frac_bits_q = pwdata[FRAC_W-1:0];
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected filtered_sample: expected none, actual %h",
                   $time, filtered_sample_i);
        end else begin
          expected = expected_samples.pop_front();
          if (filtered_sample_i !== expected) begin
            fail_count_o++;
            $display("%0t: filtered_sample mismatch: expected %h, actual %h",
                     $time, expected, filtered_sample_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_COEF) begin
          if (coef_index_i < MAX_TAPS) begin
            coef_shadow[coef_index_i] = value_i;
          end
        end else begin
          for (int k = MAX_TAPS - 1; k > 0; k--) begin
            sample_history[k] = sample_history[k-1];
          end
          sample_history[0] = value_i;
          expected_samples.push_back(filter_output());
        end
      end
    end
    pending_o = expected_samples.size();
  end

endmodule

>>> tb/tb_fixed_point_fir_filter.sv
`timescale 1ns / 100ps
// Testbench top for fixed_point_fir_filter: clock, reset, register writes, sample and
// coefficient stimulus with random gaps and stalls, verdict. Depends on fpfir_checker.
module tb_fixed_point_fir_filter;
  import fpfir_pkg::*;

  localparam int unsigned MAX_TAPS        = MAX_TAPS_DEF;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 63;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAP_SET [8]     = '{64, 1, 0, 127, 65, 2, 33, 8};
  localparam int unsigned FRAC_SET [8]    = '{31, 0, 16, 1, 30, 15, 0, 31};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     mode_i;
  logic [IDX_W-1:0]         coef_index_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] filtered_sample_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  int unsigned check_failures;
  int unsigned pending_results;
  int unsigned burst_left;

  fixed_point_fir_filter #(
    .MAX_TAPS(MAX_TAPS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .coef_index_i     (coef_index_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_sample_o(filtered_sample_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  fpfir_checker #(
    .MAX_TAPS(MAX_TAPS)
  ) fir_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .mode_i           (mode_i),
    .coef_index_i     (coef_index_i),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_sample_i(filtered_sample_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count_o     (check_failures),
    .pending_o        (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] rand_word();
    logic [8:0] low_bits;
    low_bits = 9'($urandom());
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return {{(DATA_W-9){low_bits[8]}}, low_bits};
      5: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic item_mode, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] word);
    int unsigned gap;
    mode_i       <= item_mode;
    coef_index_i <= idx;
    value_i      <= word;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [0:0] reg_idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (pending_results == 0);
    repeat (MAX_TAPS + 8) @(negedge clk_i);
  endtask

  task automatic program_filter(input logic [TAP_W-1:0] taps, input logic [FRAC_W-1:0] frac);
    drain_results();
    write_reg(REG_TAP_COUNT, {(APB_DATA_W-TAP_W)'($urandom()), taps});
    write_reg(REG_FRAC_BITS, {(APB_DATA_W-FRAC_W)'($urandom()), frac});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned run;
    out_stall_i = 1'b0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        if (out_stall_i) begin
          out_stall_i <= 1'b0;
          run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 24);
        end
      end else begin
        run--;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_coef;
    int unsigned taps;
    int unsigned frac;
    in_valid_i   = 1'b0;
    mode_i       = MODE_SAMPLE;
    coef_index_i = '0;
    value_i      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    burst_left   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, empty coefficient store
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h7FFF_FFFF);
    send_item(MODE_COEF, 6'd0, 32'h7FFF_FFFF);
    send_item(MODE_COEF, 6'd1, 32'h8000_0000);
    send_item(MODE_COEF, 6'd2, 32'h0000_0001);
    send_item(MODE_COEF, 6'd63, 32'hFFFF_FFFF);
    send_item(MODE_COEF, 6'd32, 32'h8000_0001);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h8000_0000);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h0000_0001);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h0000_0000);

    // empty sum: history still shifts
    program_filter(7'd0, 5'd0);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h1234_5678);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h8000_0000);

    program_filter(7'd1, 5'd0);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h8000_0000);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h7FFF_FFFF);

    // tap count above the delay line depth saturates
    program_filter(7'd127, 5'd31);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h8000_0000);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'hFFFF_FFFF);

    program_filter(7'd65, 5'd1);
    send_item(MODE_SAMPLE, IDX_W'($urandom()), 32'h0000_0005);

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      taps = (phase < 8) ? TAP_SET[phase] : $urandom_range(0, 127);
      frac = (phase < 8) ? FRAC_SET[phase] : $urandom_range(0, 31);
      program_filter(TAP_W'(taps), FRAC_W'(frac));
      n_coef = $urandom_range(0, 16);
      for (int unsigned i = 0; i < n_coef; i++) begin
        send_item(MODE_COEF, IDX_W'($urandom_range(0, 63)), rand_word());
      end
      for (int unsigned i = n_coef; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(MODE_COEF, IDX_W'($urandom_range(0, 63)), rand_word());
        end else begin
          send_item(MODE_SAMPLE, IDX_W'($urandom()), rand_word());
        end
      end
    end

    drain_results();
    if (check_failures == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
